// ===== design/qr_version_info_decoder_unit_defines.svh =====
// Assertion macros for the QR version information decoder
`ifndef QR_VERSION_INFO_DECODER_UNIT_DEFINES_SVH
`define QR_VERSION_INFO_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define QRVI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define QRVI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/qrvi_pkg.sv =====
// Types, constants and codeword table of the QR version information decoder
`timescale 1ns / 1ps
`default_nettype none

package qrvi_pkg;

    localparam int WORD_W     = 18;
    localparam int LIMIT_W    = 5;
    localparam int VER_W      = 6;
    localparam int DIST_W     = 5;
    localparam int TABLE_SIZE = 34;

    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [LIMIT_W-1:0] t_limit;
    typedef logic [VER_W-1:0]   t_ver;
    typedef logic [DIST_W-1:0]  t_dist;

    localparam t_ver   FIRST_VERSION = 6'd7;
    localparam t_limit LIMIT_RESET   = 5'd3;
    // larger than any real distance; marks an empty slot of the search tree
    localparam t_dist  DIST_NONE     = 5'd19;

    // BCH(18,6) version codewords, versions 7 to 40
    localparam t_word CODEWORDS [TABLE_SIZE] = '{
        18'h07C94, 18'h085BC, 18'h09A99, 18'h0A4D3, 18'h0BBF6, 18'h0C762,
        18'h0D847, 18'h0E60D, 18'h0F928, 18'h10B78, 18'h1145D, 18'h12A17,
        18'h13532, 18'h149A6, 18'h15683, 18'h168C9, 18'h177EC, 18'h18EC4,
        18'h191E1, 18'h1AFAB, 18'h1B08E, 18'h1CC1A, 18'h1D33F, 18'h1ED75,
        18'h1F250, 18'h209D5, 18'h216F0, 18'h228BA, 18'h2379F, 18'h24B0B,
        18'h2542E, 18'h26A64, 18'h27541, 18'h28C69
    };

endpackage

`default_nettype wire

// ===== design/qrvi_if.sv =====
// Valid/ready channel interfaces for input and result words
`timescale 1ns / 1ps
`default_nettype none

interface qrvi_in_if
    import qrvi_pkg::*;
();
    logic  valid;
    logic  ready;
    t_word version_bits;

    modport source (output valid, output version_bits, input ready);
    modport sink   (input valid, input version_bits, output ready);
endinterface

interface qrvi_out_if
    import qrvi_pkg::*;
();
    logic valid;
    logic ready;
    logic found;
    t_ver version_number;

    modport source (output valid, output found, output version_number, input ready);
    modport sink   (input valid, input found, input version_number, output ready);
endinterface

`default_nettype wire

// ===== design/qr_version_info_decoder_unit.sv =====
// A word accepted into the input register moves on to the result register once the result side has room.
// Throughput: one word per cycle while the result side accepts; distance and minimum search sit between the input
// register and the result register, with ready chained back from the result side.
// Reset (synchronous, active low): both pipeline stages empty, error limit back to 3.
// Codeword search covers versions 7 to 6+NUM_CODEWORDS.
`timescale 1ns / 1ps
`default_nettype none
`include "qr_version_info_decoder_unit_defines.svh"

module qr_version_info_decoder_unit
    import qrvi_pkg::*;
#(
    parameter int NUM_CODEWORDS = 34
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  t_limit      i_cfg_wr_data,
    qrvi_in_if.sink     i_in,
    qrvi_out_if.source  o_out
);

    localparam int IDX_W = (NUM_CODEWORDS > 1) ? $clog2(NUM_CODEWORDS) : 1;

    t_limit r_limit;

    logic  r_s1_valid;
    t_word r_s1_word;

    logic r_out_valid;
    logic r_out_found;
    t_ver r_out_version;

    logic w_s2_load;
    logic w_s1_load;

    t_dist            w_dist [NUM_CODEWORDS];
    t_dist            w_best_dist;
    logic [IDX_W-1:0] w_best_idx;
    logic             n_found;
    t_ver             n_version;

    // error limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_limit <= i_cfg_wr_data;
        end
    end

    assign w_s2_load  = r_s1_valid && (!r_out_valid || o_out.ready);
    assign w_s1_load  = i_in.valid && i_in.ready;
    assign i_in.ready = !r_s1_valid || w_s2_load;

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_load) begin
            r_s1_word <= i_in.version_bits;
        end
    end

    qrvi_dist #(
        .NUM_CODEWORDS (NUM_CODEWORDS)
    ) u_dist (
        .i_word (r_s1_word),
        .o_dist (w_dist)
    );

    qrvi_min #(
        .NUM_CODEWORDS (NUM_CODEWORDS),
        .IDX_W         (IDX_W)
    ) u_min (
        .i_dist      (w_dist),
        .o_best_dist (w_best_dist),
        .o_best_idx  (w_best_idx)
    );

    assign n_found   = (w_best_dist <= r_limit);
    assign n_version = n_found ? (FIRST_VERSION + VER_W'(w_best_idx)) : '0;

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || o_out.ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_load) begin
            r_out_found   <= n_found;
            r_out_version <= n_version;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.found          = r_out_found;
    assign o_out.version_number = r_out_version;

    `QRVI_ASSERT_NOW(a_found_ver_range, r_out_valid && r_out_found,
        r_out_version >= FIRST_VERSION &&
        r_out_version <= VER_W'(FIRST_VERSION + NUM_CODEWORDS - 1),
        "found result carries a version outside the table")
    `QRVI_ASSERT_NOW(a_miss_ver_zero, r_out_valid && !r_out_found,
        r_out_version == '0, "not-found result carries a nonzero version")
    `QRVI_ASSERT_NEXT(a_stage_advance, w_s2_load, r_out_valid,
        "word moved to result stage but result not valid")
    `QRVI_ASSERT_NOW(a_exact_hit, r_s1_valid && w_best_dist == '0,
        n_found, "exact codeword match not reported as found")

endmodule

`default_nettype wire

// ===== design/qrvi_dist.sv =====
// Hamming distance of one word to every codeword of the table
`timescale 1ns / 1ps
`default_nettype none

module qrvi_dist
    import qrvi_pkg::*;
#(
    parameter int NUM_CODEWORDS = 34
) (
    input  t_word i_word,
    output t_dist o_dist [NUM_CODEWORDS]
);

    always_comb begin
        for (int i = 0; i < NUM_CODEWORDS; i++) begin
            o_dist[i] = DIST_W'($countones(i_word ^ CODEWORDS[i]));
        end
    end

endmodule

`default_nettype wire

// ===== design/qrvi_min.sv =====
// Minimum search over the distances; a tie goes to the lower index
`timescale 1ns / 1ps
`default_nettype none

module qrvi_min
    import qrvi_pkg::*;
#(
    parameter int NUM_CODEWORDS = 34,
    parameter int IDX_W         = 6
) (
    input  t_dist            i_dist [NUM_CODEWORDS],
    output t_dist            o_best_dist,
    output logic [IDX_W-1:0] o_best_idx
);

    localparam int LVL  = $clog2(NUM_CODEWORDS);
    localparam int SLOT = 1 << LVL;

    t_dist            tree_d [LVL+1][SLOT];
    logic [IDX_W-1:0] tree_i [LVL+1][SLOT];

    always_comb begin
        for (int l = 0; l <= LVL; l++) begin
            for (int s = 0; s < SLOT; s++) begin
                tree_d[l][s] = DIST_NONE;
                tree_i[l][s] = IDX_W'(s);
            end
        end
        for (int s = 0; s < NUM_CODEWORDS; s++) begin
            tree_d[0][s] = i_dist[s];
        end
        for (int l = 0; l < LVL; l++) begin
            for (int s = 0; s < (SLOT >> (l + 1)); s++) begin
                // strict compare keeps the left (lower) index on equal distance
                if (tree_d[l][2*s+1] < tree_d[l][2*s]) begin
                    tree_d[l+1][s] = tree_d[l][2*s+1];
                    tree_i[l+1][s] = tree_i[l][2*s+1];
                end else begin
                    tree_d[l+1][s] = tree_d[l][2*s];
                    tree_i[l+1][s] = tree_i[l][2*s];
                end
            end
        end
    end

    assign o_best_dist = tree_d[LVL][0];
    assign o_best_idx  = tree_i[LVL][0];

endmodule

`default_nettype wire

// ===== verif/qr_version_info_decoder_unit_checker.sv =====
// Scoreboard for the QR version info decoder: predicts each result word and compares it
`timescale 1ns / 1ps

module qr_version_info_decoder_unit_checker
    import qrvi_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_cfg_wr_en,
    input  t_limit i_cfg_wr_data,
    qrvi_in_if    i_in,
    qrvi_out_if   i_out,
    output int    o_fail_count,
    output int    o_pending
);

    typedef struct packed {
        logic found;
        t_ver version_number;
    } t_decode;

    localparam int NUM_VERSIONS = 34;

    // version codewords 7..40
    localparam t_word VERSION_CODES [NUM_VERSIONS] = '{
        18'h07C94, 18'h085BC, 18'h09A99, 18'h0A4D3, 18'h0BBF6, 18'h0C762,
        18'h0D847, 18'h0E60D, 18'h0F928, 18'h10B78, 18'h1145D, 18'h12A17,
        18'h13532, 18'h149A6, 18'h15683, 18'h168C9, 18'h177EC, 18'h18EC4,
        18'h191E1, 18'h1AFAB, 18'h1B08E, 18'h1CC1A, 18'h1D33F, 18'h1ED75,
        18'h1F250, 18'h209D5, 18'h216F0, 18'h228BA, 18'h2379F, 18'h24B0B,
        18'h2542E, 18'h26A64, 18'h27541, 18'h28C69
    };

    t_limit  error_limit;
    t_decode pending_decodes [$];
    int      fails = 0;

    assign o_fail_count = fails;

    // nearest codeword by Hamming distance, lowest version wins a tie
    function automatic t_decode decode_version(t_word w, t_limit lim);
        t_decode r;
        int best_dist;
        int best_idx;
        int d;
        best_dist = 19;
        best_idx  = -1;
        for (int i = 0; i < NUM_VERSIONS; i++) begin
            d = $countones(w ^ VERSION_CODES[i]);
            if (d < best_dist) begin
                best_dist = d;
                best_idx  = i;
            end
        end
        r.found          = (best_idx >= 0) && (best_dist <= int'(lim));
        r.version_number = r.found ? t_ver'(best_idx + 7) : '0;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_decode want;
        if (!i_rst_n) begin
            error_limit = LIMIT_RESET;
            pending_decodes.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_wr_en)
                error_limit = i_cfg_wr_data;
            if (i_out.valid && i_out.ready) begin
                if (pending_decodes.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result word, expected none, got found=%0d version=%0d",
                             $time, i_out.found, i_out.version_number);
                end else begin
                    want = pending_decodes.pop_front();
                    if (i_out.found !== want.found
                        || i_out.version_number !== want.version_number) begin
                        fails++;
                        $display("%0t: mismatch expected found=%0d ver=%0d, got found=%0d ver=%0d",
                                 $time, want.found, want.version_number,
                                 i_out.found, i_out.version_number);
                    end
                end
            end
            if (i_in.valid && i_in.ready)
                pending_decodes.insert(pending_decodes.size(),
                                       decode_version(i_in.version_bits, error_limit));
            o_pending <= pending_decodes.size();
        end
    end

endmodule

// ===== verif/qr_version_info_decoder_unit_test.sv =====
// Top of the QR version info decoder testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module qr_version_info_decoder_unit_test;
    import qrvi_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_WORDS = 100;

    logic   i_clk = 1'b0;
    logic   i_rst_n;
    logic   i_cfg_wr_en;
    t_limit i_cfg_wr_data;
    int     fail_count;
    int     pending;
    int     src_idle_pct;
    int     snk_idle_pct;
    int     cycle_count = 0;

    qrvi_in_if  in_ch ();
    qrvi_out_if out_ch ();

    qr_version_info_decoder_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_ch),
        .o_out         (out_ch)
    );

    qr_version_info_decoder_unit_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk)
        out_ch.ready <= i_rst_n && ($urandom_range(99) >= snk_idle_pct);

    // flip every other differing bit: a word about halfway between two codewords
    function automatic t_word midpoint(t_word a, t_word b);
        t_word w;
        t_word diff;
        logic  toggle;
        w      = a;
        diff   = a ^ b;
        toggle = 1'b0;
        for (int i = 0; i < WORD_W; i++) begin
            if (diff[i]) begin
                if (toggle)
                    w[i] = ~w[i];
                toggle = ~toggle;
            end
        end
        return w;
    endfunction

    // mostly codewords with a few bit errors, plus ties and raw noise
    function automatic t_word random_word();
        t_word w;
        int    pick;
        int    flips;
        pick = $urandom_range(99);
        if (pick < 20) begin
            w = t_word'($urandom);
        end else if (pick < 30) begin
            w = midpoint(CODEWORDS[$urandom_range(TABLE_SIZE-1)],
                         CODEWORDS[$urandom_range(TABLE_SIZE-1)]);
        end else begin
            w     = CODEWORDS[$urandom_range(TABLE_SIZE-1)];
            flips = (pick < 75) ? $urandom_range(4) : $urandom_range(9);
            repeat (flips)
                w = w ^ (t_word'(1) << $urandom_range(WORD_W-1));
        end
        return w;
    endfunction

    // valid stays high across back-to-back words
    task automatic send_word(t_word w);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.version_bits <= w;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    task automatic set_idle(int mode);
        case (mode)
            0: begin
                src_idle_pct = 25;
                snk_idle_pct = 64;
            end
            1: begin
                src_idle_pct = 64;
                snk_idle_pct = 25;
            end
            default: begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
        endcase
    endtask

    initial begin
        t_word  directed [$];
        t_limit limit_plan [7];
        t_limit lim;

        i_rst_n            = 1'b0;
        i_cfg_wr_en        = 1'b0;
        i_cfg_wr_data      = '0;
        in_ch.valid        = 1'b0;
        in_ch.version_bits = '0;
        set_idle(0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words under the reset limit of 3
        directed = '{
            18'h00000, 18'h3FFFF, 18'h2AAAA, 18'h15555,
            CODEWORDS[0], CODEWORDS[TABLE_SIZE-1],
            CODEWORDS[0] ^ 18'h00001,
            CODEWORDS[5] ^ 18'h20000,
            CODEWORDS[12] ^ 18'h00811,
            CODEWORDS[TABLE_SIZE-1] ^ 18'h20007,
            CODEWORDS[20] ^ 18'h0F000,
            midpoint(CODEWORDS[0], CODEWORDS[1]),
            midpoint(CODEWORDS[17], CODEWORDS[30])
        };
        foreach (directed[i])
            send_word(directed[i]);
        drain();

        // extremes first, then assorted limits; above 18 everything is found
        limit_plan = '{5'd0, 5'd18, 5'd31, 5'd19, 5'd1, 5'd3, 5'd2};
        for (int phase = 0; phase < 9; phase++) begin
            lim = (phase < 7) ? limit_plan[phase] : t_limit'($urandom_range(4, 17));
            i_cfg_wr_en   <= 1'b1;
            i_cfg_wr_data <= lim;
            @(posedge i_clk);
            i_cfg_wr_en   <= 1'b0;
            set_idle(phase % 3);
            repeat (PHASE_WORDS)
                send_word(random_word());
            drain();
        end

        repeat (4) @(posedge i_clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
